// ----- rtl/core/dslp_pkg.sv -----
package dslp_pkg;

  // Default buffer depth in bytes
  localparam int unsigned MaxBytesDef = 256;

  // Bytes in one half (R or S) of the compact signature
  localparam int unsigned HalfBytes = 32;
  localparam int unsigned HalfW     = 8 * HalfBytes;

  // Result words
  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = 8;
  localparam int unsigned IdxW     = 3;

  // Integer length register: at most three significant length bytes
  localparam int unsigned LenW = 24;

  // DER tags
  localparam logic [7:0] TagSeq = 8'h30;
  localparam logic [7:0] TagInt = 8'h02;

  // Long-form length: at least this many significant bytes is a reject
  localparam logic [6:0] MaxLenBytes = 7'd4;

  // secp256k1 group order n
  localparam logic [HalfW-1:0] GroupOrder =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;

  // Parse status handed from the walker to the top level
  typedef struct packed {
    logic done;
    logic accepted;
    logic overflowed;
  } parse_res_t;

endpackage

// ----- rtl/core/der_signature_lax_parser_top.sv -----
// Lenient DER parser for ECDSA (secp256k1) signatures. Feed the signature one
// byte per word on the input channel and flag the last byte with final_byte_i.
// Bytes load into an on-chip buffer of MaxBytes entries at one byte per cycle
// while the input is open; bytes beyond the buffer are dropped and the
// signature is rejected. The final byte starts a walk over the buffer through
// its single read port, visiting each header, length or value byte in turn,
// with decision steps between, then comparing R and S against the group order
// one 64-bit word at a time. Once the walk is done, eight 64-bit words
// come out, R then S, most significant first, with word_index_o 0 to 7 and
// last_word_o on word 7. A rejected signature gives accepted_o = 0 and zero
// words; an R or S too long or not below n gives overflowed_o = 1 and zero words.
// The input stays closed from the final byte until the last word is taken.
module der_signature_lax_parser_top #(
  parameter int unsigned MaxBytes = dslp_pkg::MaxBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       final_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       accepted_o,
  output logic                       overflowed_o,
  output logic [dslp_pkg::WordW-1:0] sig_word_o,
  output logic [dslp_pkg::IdxW-1:0]  word_index_o,
  output logic                       last_word_o
);

  import dslp_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxBytes);
  localparam int unsigned CntW  = $clog2(MaxBytes + 1);

  typedef enum logic [1:0] {
    T_LOAD = 2'b01,
    T_BUSY = 2'b10
  } top_state_e;

  top_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            too_long_q, too_long_d;
  logic [IdxW-1:0] widx_q, widx_d;

  logic             in_acc;
  logic             out_acc;
  logic             wr_en;
  logic             start;
  logic             release_w;
  logic [7:0]       rd_data;
  logic [AddrW-1:0] rd_addr;
  parse_res_t       res;
  logic [WordW-1:0] word;

  assign in_ready_o = (state_q == T_LOAD);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_valid_o = res.done;
  assign out_acc    = out_valid_o & out_ready_i;
  assign last_word_o = (widx_q == IdxW'(NumWords - 1));
  assign release_w  = out_acc & last_word_o;

  // Buffer the byte while there is room; flag the overrun otherwise
  assign wr_en = in_acc & (cnt_q < CntW'(MaxBytes));
  assign start = in_acc & final_byte_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    too_long_d = too_long_q;
    widx_d     = widx_q;
    case (state_q)
      T_LOAD: begin
        if (in_acc) begin
          if (wr_en) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            too_long_d = 1'b1;
          end
          if (final_byte_i) begin
            widx_d  = '0;
            state_d = T_BUSY;
          end
        end
      end
      T_BUSY: begin
        // Advance the word index per word taken; reopen after the last one
        if (out_acc) begin
          widx_d = widx_q + IdxW'(1);
          if (last_word_o) begin
            cnt_d      = '0;
            too_long_d = 1'b0;
            state_d    = T_LOAD;
          end
        end
      end
      default: state_d = T_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_LOAD;
      cnt_q      <= '0;
      too_long_q <= 1'b0;
      widx_q     <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      too_long_q <= too_long_d;
      widx_q     <= widx_d;
    end
  end

  dslp_byte_mem #(
    .Depth (MaxBytes),
    .AddrW (AddrW)
  ) u_byte_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (in_byte_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dslp_walker #(
    .MaxBytes (MaxBytes),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .release_i  (release_w),
    .len_i      (cnt_q),
    .too_long_i (too_long_q),
    .rd_data_i  (rd_data),
    .rd_addr_o  (rd_addr),
    .word_sel_i (widx_q),
    .word_o     (word),
    .res_o      (res)
  );

  assign accepted_o   = res.accepted;
  assign overflowed_o = res.overflowed;
  assign sig_word_o   = word;
  assign word_index_o = widx_q;

endmodule

// ----- rtl/core/dslp_byte_mem.sv -----
module dslp_byte_mem #(
  parameter int unsigned Depth = dslp_pkg::MaxBytesDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/dslp_walker.sv -----
module dslp_walker #(
  parameter int unsigned MaxBytes = dslp_pkg::MaxBytesDef,
  parameter int unsigned AddrW    = $clog2(MaxBytes),
  parameter int unsigned CntW     = $clog2(MaxBytes + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        release_i,
  input  logic [CntW-1:0]             len_i,
  input  logic                        too_long_i,
  input  logic [7:0]                  rd_data_i,
  output logic [AddrW-1:0]            rd_addr_o,
  input  logic [dslp_pkg::IdxW-1:0]   word_sel_i,
  output logic [dslp_pkg::WordW-1:0]  word_o,
  output dslp_pkg::parse_res_t        res_o
);

  import dslp_pkg::*;

  typedef enum logic [12:0] {
    W_IDLE = 13'b0000000000001,
    W_WAIT = 13'b0000000000010,
    W_TAG  = 13'b0000000000100,
    W_SLEN = 13'b0000000001000,
    W_ITAG = 13'b0000000010000,
    W_ILEN = 13'b0000000100000,
    W_LZ   = 13'b0000001000000,
    W_LACC = 13'b0000010000000,
    W_VCHK = 13'b0000100000000,
    W_VZ   = 13'b0001000000000,
    W_VCP  = 13'b0010000000000,
    W_CMP  = 13'b0100000000000,
    W_DONE = 13'b1000000000000
  } walk_state_e;

  walk_state_e      state_q, state_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic [6:0]       lb_q, lb_d;
  logic [LenW-1:0]  val_q, val_d;
  logic             half_q, half_d;
  logic             acc_q, acc_d;
  logic             ovf_q, ovf_d;
  logic [HalfW-1:0] r_q, r_d, s_q, s_d;
  logic [1:0]       cmp_k_q, cmp_k_d;
  logic             r_dec_q, r_dec_d, r_ge_q, r_ge_d;
  logic             s_dec_q, s_dec_d, s_ge_q, s_ge_d;

  logic [CntW-1:0]  rem;
  logic [LenW-1:0]  rem_ext;
  logic [LenW-1:0]  lbr_ext;
  logic             at_end;
  logic [7:0]       cmp_off;
  logic [WordW-1:0] r_w, s_w, ord_w;
  logic [7:0]       sel_off;
  logic [WordW-1:0] sel_w;

  assign rem     = len_i - ptr_q;
  assign rem_ext = LenW'(rem);
  assign lbr_ext = LenW'(rd_data_i[6:0]);
  assign at_end  = (ptr_q >= len_i);

  // Most significant word first
  assign cmp_off = {~cmp_k_q, 6'd0};
  assign r_w     = r_q[cmp_off +: WordW];
  assign s_w     = s_q[cmp_off +: WordW];
  assign ord_w   = GroupOrder[cmp_off +: WordW];

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    lb_d    = lb_q;
    val_d   = val_q;
    half_d  = half_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    r_d     = r_q;
    s_d     = s_q;
    cmp_k_d = cmp_k_q;
    r_dec_d = r_dec_q;
    r_ge_d  = r_ge_q;
    s_dec_d = s_dec_q;
    s_ge_d  = s_ge_q;

    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          ptr_d   = '0;
          half_d  = 1'b0;
          acc_d   = 1'b1;
          ovf_d   = 1'b0;
          r_d     = '0;
          s_d     = '0;
          cmp_k_d = '0;
          r_dec_d = 1'b0;
          r_ge_d  = 1'b0;
          s_dec_d = 1'b0;
          s_ge_d  = 1'b0;
          state_d = W_WAIT;
        end
      end
      // Let the final byte land before the first read
      W_WAIT: state_d = W_TAG;
      W_TAG: begin
        if (too_long_i || at_end || rd_data_i != TagSeq) begin
          acc_d   = 1'b0;
          state_d = W_DONE;
        end else begin
          ptr_d   = ptr_q + CntW'(1);
          state_d = W_SLEN;
        end
      end
      W_SLEN: begin
        if (at_end) begin
          acc_d   = 1'b0;
          state_d = W_DONE;
        end else if (rd_data_i[7]) begin
          // Skip long-form sequence length bytes
          if (lbr_ext >= rem_ext) begin
            acc_d   = 1'b0;
            state_d = W_DONE;
          end else begin
            ptr_d   = ptr_q + CntW'(1) + CntW'(rd_data_i[6:0]);
            state_d = W_ITAG;
          end
        end else begin
          ptr_d   = ptr_q + CntW'(1);
          state_d = W_ITAG;
        end
      end
      W_ITAG: begin
        if (at_end || rd_data_i != TagInt) begin
          acc_d   = 1'b0;
          state_d = W_DONE;
        end else begin
          ptr_d   = ptr_q + CntW'(1);
          state_d = W_ILEN;
        end
      end
      W_ILEN: begin
        if (at_end) begin
          acc_d   = 1'b0;
          state_d = W_DONE;
        end else if (rd_data_i[7]) begin
          if (lbr_ext >= rem_ext) begin
            acc_d   = 1'b0;
            state_d = W_DONE;
          end else begin
            ptr_d   = ptr_q + CntW'(1);
            lb_d    = rd_data_i[6:0];
            val_d   = '0;
            state_d = W_LZ;
          end
        end else begin
          ptr_d   = ptr_q + CntW'(1);
          val_d   = LenW'(rd_data_i);
          state_d = W_VCHK;
        end
      end
      W_LZ: begin
        // Drop leading zero length bytes
        if (lb_q != '0 && rd_data_i == 8'h00) begin
          ptr_d = ptr_q + CntW'(1);
          lb_d  = lb_q - 7'd1;
        end else if (lb_q >= MaxLenBytes) begin
          acc_d   = 1'b0;
          state_d = W_DONE;
        end else if (lb_q == '0) begin
          state_d = W_VCHK;
        end else begin
          state_d = W_LACC;
        end
      end
      W_LACC: begin
        val_d = {val_q[LenW-9:0], rd_data_i};
        ptr_d = ptr_q + CntW'(1);
        lb_d  = lb_q - 7'd1;
        if (lb_q == 7'd1) begin
          state_d = W_VCHK;
        end
      end
      W_VCHK: begin
        if (val_q > rem_ext) begin
          acc_d   = 1'b0;
          state_d = W_DONE;
        end else begin
          state_d = W_VZ;
        end
      end
      W_VZ: begin
        // Strip leading zero value bytes
        if (val_q != '0 && rd_data_i == 8'h00) begin
          ptr_d = ptr_q + CntW'(1);
          val_d = val_q - LenW'(1);
        end else if (val_q > LenW'(HalfBytes)) begin
          ovf_d = 1'b1;
          ptr_d = ptr_q + CntW'(val_q);
          val_d = '0;
          if (half_q) begin
            state_d = W_CMP;
          end else begin
            half_d  = 1'b1;
            state_d = W_ITAG;
          end
        end else begin
          state_d = W_VCP;
        end
      end
      W_VCP: begin
        if (val_q != '0) begin
          // Shift in from the right: the value ends up right-aligned
          if (half_q) begin
            s_d = {s_q[HalfW-9:0], rd_data_i};
          end else begin
            r_d = {r_q[HalfW-9:0], rd_data_i};
          end
          ptr_d = ptr_q + CntW'(1);
          val_d = val_q - LenW'(1);
        end else if (half_q) begin
          state_d = W_CMP;
        end else begin
          half_d  = 1'b1;
          state_d = W_ITAG;
        end
      end
      W_CMP: begin
        // Word-serial compare of R and S against n
        if (!r_dec_q) begin
          r_dec_d = (r_w != ord_w);
          r_ge_d  = (r_w > ord_w);
        end
        if (!s_dec_q) begin
          s_dec_d = (s_w != ord_w);
          s_ge_d  = (s_w > ord_w);
        end
        cmp_k_d = cmp_k_q + 2'd1;
        if (cmp_k_q == 2'd3) begin
          ovf_d   = ovf_q | (r_dec_d ? r_ge_d : 1'b1) | (s_dec_d ? s_ge_d : 1'b1);
          state_d = W_DONE;
        end
      end
      W_DONE: begin
        if (release_i) begin
          state_d = W_IDLE;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      ptr_q   <= '0;
      acc_q   <= 1'b0;
      ovf_q   <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lb_q    <= lb_d;
    val_q   <= val_d;
    r_q     <= r_d;
    s_q     <= s_d;
    cmp_k_q <= cmp_k_d;
    r_dec_q <= r_dec_d;
    r_ge_q  <= r_ge_d;
    s_dec_q <= s_dec_d;
    s_ge_q  <= s_ge_d;
  end

  // Address the next pointer so the read data matches ptr_q
  assign rd_addr_o = ptr_d[AddrW-1:0];

  assign sel_off = {~word_sel_i[1:0], 6'd0};
  assign sel_w   = word_sel_i[2] ? s_q[sel_off +: WordW] : r_q[sel_off +: WordW];
  assign word_o  = (acc_q && !ovf_q) ? sel_w : '0;

  assign res_o.done       = (state_q == W_DONE);
  assign res_o.accepted   = acc_q;
  assign res_o.overflowed = acc_q & ovf_q;

endmodule

// ----- rtl/core/dslp_checker.sv -----
module dslp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  in_byte_i,
  input logic        final_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        accepted_o,
  input logic        overflowed_o,
  input logic [63:0] sig_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // Input stays closed while results go out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input open while words pending");

  // Close the input after a final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && final_byte_i) |=> !in_ready_o)
    else $error("input still open after final byte");

  // Rejected or overflowed signatures carry zero words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (!accepted_o || overflowed_o)) |-> (sig_word_o == 64'd0))
    else $error("nonzero word on reject or overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflowed_o) |-> accepted_o)
    else $error("overflow flagged on rejected signature");

  // Words of one signature follow in order without a gap in valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_word_o) |=>
      (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("word sequence broken");

endmodule

bind der_signature_lax_parser_top dslp_checker u_dslp_checker (.*);

// ----- verif/dslp_tb_pkg.sv -----
package dslp_tb_pkg;
  import dslp_pkg::*;

  typedef struct packed {
    logic             accepted;
    logic             overflowed;
    logic [WordW-1:0] sig_word;
    logic [IdxW-1:0]  word_index;
    logic             last_word;
  } sig_word_t;

  class compact_sig_board;
    logic [7:0]  sig_bytes [MaxBytesDef];
    int unsigned n_held;
    bit          overrun;
    sig_word_t   expected_words [$];
    int unsigned n_errors;

    function new();
      n_held   = 0;
      overrun  = 1'b0;
      n_errors = 0;
    endfunction

    // Tag, length, then the value's position and size; 0 on reject.
    function bit fetch_int(input int unsigned len, inout int unsigned pos,
                           output int unsigned vpos, output int unsigned vlen);
      int unsigned p, nb, l;
      p    = pos;
      vpos = 0;
      vlen = 0;
      if (p >= len || sig_bytes[p] != TagInt) return 1'b0;
      p++;
      if (p >= len) return 1'b0;
      nb = sig_bytes[p];
      p++;
      if (nb[7]) begin
        nb = nb - 32'h80;
        if (nb > len - p) return 1'b0;
        while (nb > 0 && sig_bytes[p] == 8'h00) begin
          p++;
          nb--;
        end
        if (nb >= MaxLenBytes) return 1'b0;
        l = 0;
        while (nb > 0) begin
          l = (l << 8) + sig_bytes[p];
          p++;
          nb--;
        end
      end else begin
        l = nb;
      end
      if (l > len - p) return 1'b0;
      vpos = p;
      vlen = l;
      pos  = p + l;
      return 1'b1;
    endfunction

    // Strip leading zeros and right-align; 1 if the value does not fit.
    function bit align_value(input int unsigned vpos, input int unsigned vlen,
                             output logic [HalfW-1:0] val);
      int unsigned i;
      val = '0;
      while (vlen > 0 && sig_bytes[vpos] == 8'h00) begin
        vpos++;
        vlen--;
      end
      if (vlen > HalfBytes) return 1'b1;
      for (i = 0; i < vlen; i++) val = {val[HalfW-9:0], sig_bytes[vpos + i]};
      return 1'b0;
    endfunction

    function void parse_held();
      int unsigned      len, pos, nb, rpos, rlen, spos, slen, k;
      logic [HalfW-1:0] r_val, s_val;
      logic [2*HalfW-1:0] both;
      bit               ok, ovf;
      sig_word_t        w;
      len   = n_held;
      ok    = 1'b0;
      ovf   = 1'b0;
      r_val = '0;
      s_val = '0;
      if (!overrun && len > 1 && sig_bytes[0] == TagSeq) begin
        ok  = 1'b1;
        nb  = sig_bytes[1];
        pos = 2;
        if (nb[7]) begin
          nb = nb - 32'h80;
          if (nb > len - pos) ok = 1'b0;
          else pos += nb;
        end
        if (ok) ok = fetch_int(len, pos, rpos, rlen);
        if (ok) ok = fetch_int(len, pos, spos, slen);
        if (ok) begin
          if (align_value(rpos, rlen, r_val)) ovf = 1'b1;
          if (align_value(spos, slen, s_val)) ovf = 1'b1;
          if (r_val >= GroupOrder || s_val >= GroupOrder) ovf = 1'b1;
        end
      end
      if (!ok || ovf) begin
        r_val = '0;
        s_val = '0;
      end
      both = {r_val, s_val};
      for (k = 0; k < NumWords; k++) begin
        w.accepted   = ok;
        w.overflowed = ovf;
        w.sig_word   = both[2*HalfW-1-WordW*k -: WordW];
        w.word_index = IdxW'(k);
        w.last_word  = (k == NumWords - 1);
        expected_words.push_back(w);
      end
      n_held  = 0;
      overrun = 1'b0;
    endfunction

    function void note_byte(input logic [7:0] data, input logic fin);
      if (n_held < MaxBytesDef) begin
        sig_bytes[n_held] = data;
        n_held++;
      end else begin
        overrun = 1'b1;
      end
      if (fin) parse_held();
    endfunction

    function void check_word(input sig_word_t got);
      sig_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word: word_index %0d sig_word %h", got.word_index, got.sig_word);
        n_errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
        n_errors++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
        n_errors++;
      end
      if (got.sig_word !== want.sig_word) begin
        $error("sig_word: expected %h, got %h", want.sig_word, got.sig_word);
        n_errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
        n_errors++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
        n_errors++;
      end
    endfunction
  endclass

endpackage

// ----- verif/der_signature_lax_parser_top_tb.sv -----
module der_signature_lax_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dslp_pkg::*;
  import dslp_tb_pkg::*;

  typedef logic [7:0] octet_q_t [$];

  // How the sequence length is written in front of the two integers
  typedef enum int unsigned {
    SeqShort,
    SeqLong,
    SeqJunk
  } seq_mode_t;

  localparam int unsigned HalfPeriod   = 6;
  localparam int unsigned ResetCycles  = 6;
  localparam int unsigned IdlePct      = 12;
  localparam int unsigned RandMinBytes = 250;
  localparam int unsigned RandMinSigs  = 16;
  localparam int unsigned DrainCycles  = 64;
  localparam int unsigned LimitCycles  = 200_000;
  localparam logic [7:0]  LongForm     = 8'h80;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [7:0]          in_byte_i    = 8'h00;
  logic                final_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic                accepted_o;
  logic                overflowed_o;
  logic [WordW-1:0]    sig_word_o;
  logic [IdxW-1:0]     word_index_o;
  logic                last_word_o;

  // Set during a stretch of the random part: both sides run without gaps
  bit steady = 1'b0;

  compact_sig_board board = new();

  der_signature_lax_parser_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .accepted_o   (accepted_o),
    .overflowed_o (overflowed_o),
    .sig_word_o   (sig_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  always begin
    clk_i = 1'b1;
    #(HalfPeriod);
    clk_i = 1'b0;
    #(HalfPeriod);
  end

  // Offer one input word, maybe after a few idle cycles, and hold it until
  // taken. Handshake signals are read right after the edge, so they carry
  // the values the block saw at that edge.
  task automatic push_byte(input logic [7:0] data, input logic fin);
    if (!steady) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= data;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_byte(data, fin);
  endtask

  // Send a whole signature; the last byte carries the final flag.
  task automatic send_sig(input octet_q_t sig);
    foreach (sig[i]) push_byte(sig[i], i == sig.size() - 1);
  endtask

  // Append a DER length, short form where allowed, else 0x80|count with
  // pad leading zero length bytes before the significant ones.
  function automatic void put_len(inout octet_q_t q, input int unsigned n,
                                  input bit long_form, input int unsigned pad);
    octet_q_t    digits;
    int unsigned v;
    v = n;
    while (v != 0) begin
      digits.push_front(v[7:0]);
      v = v >> 8;
    end
    if (!long_form && n < 128) begin
      q.push_back(n[7:0]);
    end else begin
      q.push_back(LongForm | 8'(pad + digits.size()));
      repeat (pad) q.push_back(8'h00);
      foreach (digits[i]) q.push_back(digits[i]);
    end
  endfunction

  function automatic void put_int(inout octet_q_t q, input octet_q_t val,
                                  input bit long_form, input int unsigned pad);
    q.push_back(TagInt);
    put_len(q, val.size(), long_form, pad);
    foreach (val[i]) q.push_back(val[i]);
  endfunction

  function automatic void build_sig(output octet_q_t sig, input octet_q_t r_val,
                                    input octet_q_t s_val, input bit int_long,
                                    input int unsigned pad, input seq_mode_t mode);
    octet_q_t body;
    put_int(body, r_val, int_long, pad);
    put_int(body, s_val, int_long, pad);
    sig = {};
    sig.push_back(TagSeq);
    case (mode)
      SeqShort: put_len(sig, body.size(), 1'b0, 0);
      SeqLong:  put_len(sig, body.size(), 1'b1, $urandom_range(2));
      default:  sig.push_back(8'($urandom_range(255)));
    endcase
    foreach (body[i]) sig.push_back(body[i]);
  endfunction

  // Pick an R or S: mostly short, some full width, some near or above the
  // group order, some with leading zeros, some too long to fit.
  function automatic octet_q_t rand_value();
    octet_q_t    v;
    int unsigned pick, n, i;
    pick = $urandom_range(99);
    if (pick < 40)      n = $urandom_range(4);
    else if (pick < 65) n = $urandom_range(32, 1);
    else if (pick < 80) n = HalfBytes;
    else                n = $urandom_range(40, 33);
    for (i = 0; i < n; i++) v.push_back(8'($urandom_range(255)));
    if (pick >= 65 && pick < 80) begin
      // top half equal to or just above the order's top half
      for (i = 0; i < 15; i++) v[i] = 8'hFF;
      v[15] = $urandom_range(1) ? 8'hFF : 8'hFE;
    end else if (pick >= 80 && pick < 90) begin
      // leading zeros that strip back to at most 32 bytes
      for (i = 0; i < n - HalfBytes; i++) v[i] = 8'h00;
    end else if (pick >= 90) begin
      v[0] = 8'($urandom_range(255, 1));
    end
    return v;
  endfunction

  task automatic run_directed();
    octet_q_t sig, none, one, n_val, n_minus, wide, zeros;
    int       i;
    one = {8'h01};
    for (i = HalfBytes - 1; i >= 0; i--) n_val.push_back(GroupOrder[8*i +: 8]);
    n_minus = n_val;
    n_minus[HalfBytes-1] = n_minus[HalfBytes-1] - 8'd1;

    // smallest well-formed signature, then empty R and S
    build_sig(sig, one, one, 1'b0, 0, SeqShort);
    send_sig(sig);
    build_sig(sig, none, none, 1'b0, 0, SeqShort);
    send_sig(sig);
    // long-form sequence length, long-form integer lengths with zero padding
    build_sig(sig, one, one, 1'b1, 3, SeqLong);
    send_sig(sig);
    // four significant length bytes
    sig = {TagSeq, 8'h08, TagInt, LongForm | 8'h04, 8'h01, 8'h00, 8'h00, 8'h00,
           8'h01, 8'h01};
    send_sig(sig);
    // R length past the end, sequence length past the end
    sig = {TagSeq, 8'h06, TagInt, 8'h05, 8'h01, TagInt, 8'h01, 8'h01};
    send_sig(sig);
    sig = {TagSeq, LongForm | 8'h05, 8'h00};
    send_sig(sig);
    // wrong tags on the sequence, on R and on S
    sig = {TagSeq + 8'd1, 8'h06, TagInt, 8'h01, 8'h01, TagInt, 8'h01, 8'h01};
    send_sig(sig);
    sig = {TagSeq, 8'h06, TagInt + 8'd1, 8'h01, 8'h01, TagInt, 8'h01, 8'h01};
    send_sig(sig);
    sig = {TagSeq, 8'h06, TagInt, 8'h01, 8'h01, TagInt + 8'd3, 8'h01, 8'h01};
    send_sig(sig);
    // truncated: tag only, tag and length, S cut before its length
    sig = {TagSeq};
    send_sig(sig);
    sig = {TagSeq, 8'h02};
    send_sig(sig);
    sig = {TagSeq, 8'h06, TagInt, 8'h01, 8'h01, TagInt};
    send_sig(sig);
    // n - 1 passes; S with a leading zero strips back to 32 bytes
    wide = {8'h00};
    foreach (n_minus[j]) wide.push_back(n_minus[j]);
    build_sig(sig, n_minus, wide, 1'b0, 0, SeqShort);
    send_sig(sig);
    // R equal to n
    build_sig(sig, n_val, one, 1'b0, 0, SeqShort);
    send_sig(sig);
    // S of 33 significant bytes
    wide = {};
    repeat (HalfBytes + 1) wide.push_back(8'hFF);
    build_sig(sig, one, wide, 1'b0, 0, SeqShort);
    send_sig(sig);
    // all-ones R, all-zero S
    wide = {};
    repeat (HalfBytes) wide.push_back(8'hFF);
    repeat (HalfBytes) zeros.push_back(8'h00);
    build_sig(sig, wide, zeros, 1'b1, 0, SeqShort);
    send_sig(sig);
    // wrong sequence length and trailing bytes, both ignored
    sig = {TagSeq, 8'h7F, TagInt, 8'h01, 8'hFF, TagInt, 8'h01, 8'h00, 8'hFF, 8'h00,
           8'hAA};
    send_sig(sig);
    // zero length in long form, empty long-form sequence length
    sig = {TagSeq, 8'h06, TagInt, LongForm, TagInt, LongForm | 8'h01, 8'h01, 8'h07};
    send_sig(sig);
    sig = {TagSeq, LongForm, TagInt, 8'h01, 8'h01, TagInt, 8'h01, 8'h01};
    send_sig(sig);
    // exactly a full buffer passes, one byte more is dropped and rejects
    build_sig(sig, one, one, 1'b0, 0, SeqShort);
    while (sig.size() < MaxBytesDef) sig.push_back(8'h00);
    send_sig(sig);
    sig.push_back(8'h00);
    send_sig(sig);
  endtask

  task automatic run_random();
    octet_q_t    sig, r_val, s_val;
    seq_mode_t   mode;
    int unsigned n_sigs, n_bytes, pick, cut, i;
    n_sigs  = 0;
    n_bytes = 0;
    while (n_bytes < RandMinBytes || n_sigs < RandMinSigs) begin
      steady = (n_sigs >= 4 && n_sigs < 9);
      r_val  = rand_value();
      s_val  = rand_value();
      pick   = $urandom_range(99);
      mode   = (pick < 60) ? SeqShort : (pick < 85) ? SeqLong : SeqJunk;
      build_sig(sig, r_val, s_val, $urandom_range(99) < 30, $urandom_range(3), mode);
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(3, 1)) sig.push_back(8'($urandom_range(255)));
      end
      // break a few: flip a byte, cut short, or replace with noise
      pick = $urandom_range(99);
      if (pick < 8) begin
        i = $urandom_range(sig.size() - 1);
        sig[i] = sig[i] ^ 8'($urandom_range(255, 1));
      end else if (pick < 14) begin
        cut = $urandom_range(sig.size() - 1, 1);
        while (sig.size() > cut) void'(sig.pop_back());
      end else if (pick < 20) begin
        sig = {};
        repeat ($urandom_range(12, 1)) sig.push_back(8'($urandom_range(255)));
      end
      send_sig(sig);
      n_sigs++;
      n_bytes += sig.size();
    end
    steady = 1'b0;
  endtask

  // Take result words with random back-pressure and check each one.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        board.check_word('{accepted_o, overflowed_o, sig_word_o, word_index_o,
                           last_word_o});
      end
      out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    // drop valid once the last byte is taken
    in_valid_i <= 1'b0;
    while (board.expected_words.size() != 0) @(posedge clk_i);
    // hold a while so any stray result word shows up
    repeat (DrainCycles) @(posedge clk_i);
    if (board.n_errors == 0) begin
      $display("der_signature_lax_parser_top_tb passed");
    end else begin
      $display("der_signature_lax_parser_top_tb failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #(LimitCycles * 2 * HalfPeriod);
    $display("der_signature_lax_parser_top_tb failed");
    $finish;
  end

endmodule

// ----- der_signature_lax_parser_top.f -----
rtl/core/dslp_pkg.sv
rtl/core/dslp_byte_mem.sv
rtl/core/dslp_walker.sv
rtl/core/der_signature_lax_parser_top.sv
rtl/core/dslp_checker.sv
verif/dslp_tb_pkg.sv
verif/der_signature_lax_parser_top_tb.sv
